[rtl/core/pmid_pkg.sv]
// shared types, widths and register codes of the periodic minimum-image distance unit
package pmid_pkg;

   localparam int COORD_W   = 24;              // coordinate and box limit width
   localparam int FRAC_BITS = 12;              // fraction bits of the fixed-point format
   localparam int PER_W     = COORD_W + 1;     // period high - low
   localparam int TQ_W      = COORD_W + 3;     // quarter / three-quarter points, 3 * period
   localparam int D_W       = COORD_W + 3;     // folded signed difference
   localparam int SQ_W      = 2 * COORD_W + 3; // one squared difference, below 2^(2*COORD_W+2)
   localparam int SUM_W     = SQ_W + 1;        // sum of three squares
   localparam int ROOT_W    = SUM_W / 2;       // one root bit per cell
   localparam int REM_W     = ROOT_W + 2;      // partial remainder
   localparam int DIST_W    = COORD_W + 2;     // distance output field

   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = ((DIST_W + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y_LOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y_HIGH = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z_LOW  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z_HIGH = CSR_IDX_W'(5);

   localparam logic signed [COORD_W-1:0] BOX_LOW_RESET  = '0;
   localparam logic signed [COORD_W-1:0] BOX_HIGH_RESET = COORD_W'(100 * (1 << FRAC_BITS));

   // per-axis cell limits, derived from the box registers
   typedef struct packed {
      logic signed [PER_W-1:0] per;
      logic signed [TQ_W-1:0]  quarter;
      logic signed [TQ_W-1:0]  three_q;
   } box_axis_type;

   // data handed from one root cell to the next
   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_stage_type;

endpackage

[rtl/core/periodic_minimum_image_distance_unit.sv]
// top level of the periodic minimum-image distance unit
//
// usage
// - req channel: one transfer carries a point pair, req_tdata packs first_x, first_y,
//   first_z, other_x, other_y, other_z (24-bit signed Q12.12 each) from bit 0 up
// - rsp channel: one transfer per pair, rsp_tdata[25:0] is the distance in unsigned
//   Q14.12 with the square root truncated, upper bits zero
// - csr port: write-only box limits, index 0..5 = x low, x high, y low, y high, z low,
//   z high; other indexes are dropped; write only while no pair is in flight
// - throughput: one pair per cycle while req_tready is high, set by the 26-cell square-root
//   chain that takes one root bit per cell and hands its remainder to the next cell
// - path: an accepted pair passes the fold, square and sum registers, the 26 root cells
//   and the output register before it shows on rsp_tvalid
// - reset: box limits return to a 0..100.0 cube, every pipeline stage empties
// - stall: when rsp_tready is low the output register holds, one more result parks in
//   a skid register and req_tready drops only while that skid register is full, so
//   the whole chain freezes in place and nothing is lost
module periodic_minimum_image_distance_unit import pmid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_x, first_y, first_z, other_x, other_y, other_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // distance, zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata
);

   // box registers, one low/high pair per axis
   logic signed [COORD_W-1:0] box_low_ff  [3];
   logic signed [COORD_W-1:0] box_high_ff [3];
   logic signed [COORD_W-1:0] box_low_in  [3];
   logic signed [COORD_W-1:0] box_high_in [3];
   box_axis_type              box_ff      [3];
   box_axis_type              box_in      [3];

   // pipeline control
   logic                      adv;
   logic                      take;
   logic                      v_fold_ff;
   logic                      v_sq_ff;
   logic                      v_sum_ff;
   logic [SQ_W-1:0]           square [3];
   logic [SUM_W-1:0]          sum_ff;
   root_stage_type            chain [ROOT_W+1];

   // output register and skid
   logic                      rsp_valid_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic                      skid_valid_ff;
   logic [DIST_W-1:0]         skid_dist_ff;
   logic                      tail_valid;
   logic [DIST_W-1:0]         tail_dist;

   // configuration writes, next value of the box registers
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         box_low_in[a]  = box_low_ff[a];
         box_high_in[a] = box_high_ff[a];
      end
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_low_in[a]  = BOX_LOW_RESET;
            box_high_in[a] = BOX_HIGH_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BOX_X_LOW:  box_low_in[0]  = csr_wdata;
            REG_BOX_X_HIGH: box_high_in[0] = csr_wdata;
            REG_BOX_Y_LOW:  box_low_in[1]  = csr_wdata;
            REG_BOX_Y_HIGH: box_high_in[1] = csr_wdata;
            REG_BOX_Z_LOW:  box_low_in[2]  = csr_wdata;
            REG_BOX_Z_HIGH: box_high_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         box_low_ff[a]  <= box_low_in[a];
         box_high_ff[a] <= box_high_in[a];
      end
   end

   // period and quarter points, floor shifts on the signed period
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [PER_W-1:0] per;
         logic signed [TQ_W-1:0]  per_e;
         logic signed [TQ_W-1:0]  three;
         logic signed [TQ_W-1:0]  low_e;
         per   = PER_W'(box_high_in[a]) - PER_W'(box_low_in[a]);
         per_e = TQ_W'(per);
         three = per_e + (per_e <<< 1);
         low_e = TQ_W'(box_low_in[a]);
         box_in[a].per     = per;
         box_in[a].quarter = low_e + (per_e >>> 2);
         box_in[a].three_q = low_e + (three >>> 2);
      end
   end

   // registered from the next register values, so the compare in the lanes starts
   // from a flop and a pair right after a write already sees the new cell
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         box_ff[a] <= box_in[a];
      end
   end

   // the chain moves while the skid register has room
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   for (genvar a = 0; a < 3; a++) begin : g_lane
      pmid_axis_lane u_lane (
         .clock  (clock),
         .enable (adv),
         .first  (req_tdata[a*COORD_W +: COORD_W]),
         .other  (req_tdata[(a+3)*COORD_W +: COORD_W]),
         .box    (box_ff[a]),
         .square (square[a])
      );
   end

   // valid bits beside the fold, square and sum stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v_fold_ff <= 1'b0;
         v_sq_ff   <= 1'b0;
         v_sum_ff  <= 1'b0;
      end else if (adv) begin
         v_fold_ff <= req_tvalid;
         v_sq_ff   <= v_fold_ff;
         v_sum_ff  <= v_sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= SUM_W'(square[0]) + SUM_W'(square[1]) + SUM_W'(square[2]);
      end
   end

   // square-root chain, two radicand bits per cell
   always_comb begin
      chain[0].valid = v_sum_ff;
      chain[0].rad   = sum_ff;
      chain[0].rem   = '0;
      chain[0].root  = '0;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      pmid_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (adv),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign tail_valid = adv && chain[ROOT_W].valid;
   assign tail_dist  = DIST_W'(chain[ROOT_W].root);
   assign take       = rsp_valid_ff && rsp_tready;

   // output register with a one-entry skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (take || !rsp_valid_ff) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               rsp_dist_ff   <= skid_dist_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= tail_valid;
               rsp_dist_ff  <= tail_dist;
            end
         end else if (tail_valid) begin
            // receiver stalled, park the arriving result
            skid_valid_ff <= 1'b1;
            skid_dist_ff  <= tail_dist;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_dist_ff);

   // a parked result always has one in front of it
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // the skid register only fills on a stalled transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_tready))
      else $error("skid register filled without a stall");

   // a result leaving the chain during a stall is kept
   assert property (@(posedge clock) disable iff (reset)
      (tail_valid && rsp_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("result dropped during stall");

   // a frozen chain keeps its tail result
   assert property (@(posedge clock) disable iff (reset)
      (!adv && chain[ROOT_W].valid) |=> (chain[ROOT_W].valid && $stable(chain[ROOT_W].root)))
      else $error("root chain moved while stalled");

endmodule

[rtl/core/pmid_axis_lane.sv]
// one axis: periodic fold of the difference, then its square
module pmid_axis_lane import pmid_pkg::*; (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [COORD_W-1:0] first,
   input  logic signed [COORD_W-1:0] other,
   input  box_axis_type              box,
   output logic [SQ_W-1:0]           square
);

   logic signed [TQ_W-1:0]  first_e;
   logic signed [TQ_W-1:0]  other_e;
   logic signed [D_W-1:0]   diff;
   logic signed [D_W-1:0]   per_e;
   logic signed [D_W-1:0]   d_in;
   logic signed [D_W-1:0]   d_ff;
   logic signed [2*D_W-1:0] prod;
   logic [SQ_W-1:0]         sq_ff;

   always_comb begin
      first_e = TQ_W'(first);
      other_e = TQ_W'(other);
      diff    = D_W'(first) - D_W'(other);
      per_e   = D_W'(box.per);
      // subtracting the period wins when both rules hold on an inverted cell
      if ((first_e > box.three_q) && (other_e < box.quarter)) begin
         d_in = diff - per_e;
      end else if ((first_e < box.quarter) && (other_e > box.three_q)) begin
         d_in = diff + per_e;
      end else begin
         d_in = diff;
      end
   end

   assign prod = d_ff * d_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff  <= d_in;
         sq_ff <= prod[SQ_W-1:0];
      end
   end

   assign square = sq_ff;

endmodule

[rtl/core/pmid_root_cell.sv]
// one digit of the restoring square root, registered toward the next cell
module pmid_root_cell import pmid_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  root_stage_type stage_in,
   output root_stage_type stage_out
);

   logic [REM_W+1:0] work;
   logic [REM_W+1:0] trial;
   root_stage_type   next_in;
   root_stage_type   next_ff;

   always_comb begin
      work          = {stage_in.rem, stage_in.rad[SUM_W-1 -: 2]};
      trial         = (REM_W+2)'({stage_in.root, 2'b01});
      next_in.valid = stage_in.valid;
      next_in.rad   = stage_in.rad << 2;
      if (work >= trial) begin
         next_in.rem  = REM_W'(work - trial);
         next_in.root = {stage_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         next_in.rem  = REM_W'(work);
         next_in.root = {stage_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (enable) begin
         next_ff.valid <= next_in.valid;
      end
      if (enable) begin
         next_ff.rad  <= next_in.rad;
         next_ff.rem  <= next_in.rem;
         next_ff.root <= next_in.root;
      end
   end

   assign stage_out = next_ff;

endmodule
